>>> rtl/core/sndu_pkg.sv
package sndu_pkg;

	localparam int ADDR_W    = 8;
	localparam int MEM_DEPTH = 256;
	localparam int VAL_W     = 16;
	localparam int FACT_W    = 16;
	localparam int PROD_W    = 32;
	localparam int STEP_W    = 48;
	localparam int ACC_W     = 41;
	localparam int DIST_W    = 40;
	localparam int TOTAL_W   = 48;
	localparam int CMD_W     = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [FACT_W-1:0] LEARNING_RATE_RST = 16'hFFFF;

	// Word index of the learning rate register (paddr bit 2).
	localparam logic REG_LEARNING_RATE = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_DIST   = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic st_read;
		logic st_mul;
		logic st_done;
		cmd_t cmd;
		logic last;
		logic first;
	} dp_ctrl_t;

endpackage

>>> rtl/core/sndu_weight_mem.sv
module sndu_weight_mem (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [sndu_pkg::ADDR_W-1:0]  rd_addr,
	output logic [sndu_pkg::VAL_W-1:0]   rd_data,
	input  logic                         wr_en,
	input  logic [sndu_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [sndu_pkg::VAL_W-1:0]   wr_data
);
	import sndu_pkg::*;

	logic [VAL_W-1:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/sndu_ctrl.sv
module sndu_ctrl #(
	parameter int PASS_LEN = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sndu_pkg::CMD_W-1:0]    cmd,
	input  logic                          last,
	input  logic                          out_free,
	output sndu_pkg::dp_ctrl_t            ctrl,
	output logic [sndu_pkg::ADDR_W-1:0]   addr
);
	import sndu_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	cmd_t              cmd_q;
	logic              last_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W:0]   idx_inc;
	logic              accept;
	logic              commit;

	// Requests with an unknown command are taken and dropped without effect.
	assign accept  = in_valid && in_ready && (cmd_t'(cmd) != CMD_NONE);
	assign commit  = (state_q == ST_DONE) && (!last_q || out_free);
	assign idx_inc = {1'b0, idx_q} + {{ADDR_W{1'b0}}, 1'b1};

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (commit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		ctrl.accept  = accept;
		ctrl.st_read = (state_q == ST_READ);
		ctrl.st_mul  = (state_q == ST_MUL);
		ctrl.st_done = commit;
		ctrl.cmd     = cmd_q;
		ctrl.last    = last_q;
		ctrl.first   = (idx_q == '0);
		addr         = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_LOAD;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cmd_q  <= cmd_t'(cmd);
				last_q <= last;
			end
			if (commit) begin
				if (last_q || (idx_inc >= (ADDR_W+1)'(PASS_LEN))) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_inc[ADDR_W-1:0];
				end
			end
		end
	end

endmodule

>>> rtl/core/sndu_datapath.sv
module sndu_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sndu_pkg::dp_ctrl_t            ctrl,
	input  logic [sndu_pkg::VAL_W-1:0]    value,
	input  logic [sndu_pkg::FACT_W-1:0]   attenuation,
	input  logic [sndu_pkg::FACT_W-1:0]   learning_rate,
	input  logic [sndu_pkg::VAL_W-1:0]    rd_data,
	output logic                          wr_en,
	output logic [sndu_pkg::VAL_W-1:0]    wr_data,
	output logic [sndu_pkg::DIST_W-1:0]   res_dist,
	output logic [sndu_pkg::TOTAL_W-1:0]  res_total
);
	import sndu_pkg::*;

	logic [VAL_W-1:0]   value_q;
	logic [FACT_W-1:0]  att_q;

	logic signed [VAL_W:0] diff;
	logic [VAL_W:0]        diff_abs;
	logic [VAL_W-1:0]      mag;
	logic [VAL_W-1:0]      mul_b;
	logic [PROD_W-1:0]     prod;

	logic [PROD_W-1:0]  prod_s2;
	logic               neg_s2;
	logic [VAL_W-1:0]   w_s2;

	logic [STEP_W-1:0]  step_prod;
	logic [ACC_W-1:0]   acc_start;
	logic [ACC_W:0]     acc_sum;

	logic [VAL_W-1:0]   step_s3;
	logic               neg_s3;
	logic [VAL_W-1:0]   w_s3;

	logic signed [VAL_W+1:0] delta;
	logic signed [VAL_W+1:0] w_new;
	logic [VAL_W-1:0]        w_sat;

	logic [ACC_W-1:0]   acc_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_nxt;

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			value_q <= value;
			att_q   <= attenuation;
		end
	end

	// Read stage: difference and the first product. A distance request squares
	// the magnitude, an update request scales it by the learning rate.
	assign diff     = $signed({value_q[VAL_W-1], value_q}) - $signed({rd_data[VAL_W-1], rd_data});
	assign diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
	assign mag      = diff_abs[VAL_W-1:0];
	assign mul_b    = (ctrl.cmd == CMD_DIST) ? mag : learning_rate;
	assign prod     = PROD_W'(mag) * PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (ctrl.st_read) begin
			prod_s2 <= prod;
			neg_s2  <= diff[VAL_W];
			w_s2    <= rd_data;
		end
	end

	// Multiply stage: attenuation product and distance accumulation.
	assign step_prod = STEP_W'(prod_s2) * STEP_W'(att_q);
	assign acc_start = ctrl.first ? '0 : acc_q;
	assign acc_sum   = {1'b0, acc_start} + (ACC_W+1)'(prod_s2);

	always_ff @(posedge clk) begin
		if (ctrl.st_mul) begin
			step_s3 <= step_prod[STEP_W-1:STEP_W-VAL_W];
			neg_s3  <= neg_s2;
			w_s3    <= w_s2;
		end
	end

	// Done stage: move the weight, rounding toward zero, and saturate.
	assign delta = neg_s3 ? -$signed({2'b00, step_s3}) : $signed({2'b00, step_s3});
	assign w_new = $signed({{2{w_s3[VAL_W-1]}}, w_s3}) + delta;

	always_comb begin
		if (w_new > $signed((VAL_W+2)'(32767))) begin
			w_sat = 16'h7FFF;
		end else if (w_new < -$signed((VAL_W+2)'(32768))) begin
			w_sat = 16'h8000;
		end else begin
			w_sat = w_new[VAL_W-1:0];
		end
	end

	assign wr_en   = ctrl.st_done && ((ctrl.cmd == CMD_LOAD) || (ctrl.cmd == CMD_UPDATE));
	assign wr_data = (ctrl.cmd == CMD_LOAD) ? value_q : w_sat;

	assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(att_q);
	assign total_nxt = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else begin
			if (ctrl.st_mul && (ctrl.cmd == CMD_DIST)) begin
				acc_q <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
			end
			if (ctrl.st_done && (ctrl.cmd == CMD_UPDATE) && ctrl.last) begin
				total_q <= total_nxt;
			end
		end
	end

	always_comb begin
		res_dist = '0;
		if (ctrl.cmd == CMD_DIST) begin
			res_dist = acc_q[ACC_W-1] ? '1 : acc_q[DIST_W-1:0];
		end
		res_total = ((ctrl.cmd == CMD_UPDATE) && ctrl.last) ? total_nxt : total_q;
	end

endmodule

>>> rtl/core/som_neuron_distance_update.sv
// An accepted request passes the weight memory read, two registered multiply
// stages and the write-back; the last element of a pass loads the result
// register, waiting while the previous result is not yet taken. No new request
// is taken until write-back ends. A request with an unknown command is taken and dropped.
// Reset clears the element counter, the distance sum, the learning-time
// total and sets the learning rate to 65535; weights stay undefined until loaded.
module som_neuron_distance_update #(
	parameter int N_WEIGHTS    = 16,
	parameter int N_COMPONENTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sndu_pkg::PADDR_W-1:0]   paddr,
	input  logic [sndu_pkg::PDATA_W-1:0]   pwdata,
	output logic [sndu_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sndu_pkg::CMD_W-1:0]     cmd,
	input  logic signed [sndu_pkg::VAL_W-1:0] value,
	input  logic [sndu_pkg::FACT_W-1:0]    attenuation,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sndu_pkg::DIST_W-1:0]    distance_sq,
	output logic [sndu_pkg::TOTAL_W-1:0]   learning_time,
	output logic [sndu_pkg::CMD_W-1:0]     pass_kind
);
	import sndu_pkg::*;

	localparam int PRODUCT  = N_WEIGHTS * N_COMPONENTS;
	localparam int PASS_LEN = (PRODUCT > MEM_DEPTH) ? MEM_DEPTH : PRODUCT;

	logic [FACT_W-1:0]  learning_rate_q;
	dp_ctrl_t           ctrl;
	logic [ADDR_W-1:0]  addr;
	logic [VAL_W-1:0]   rd_data;
	logic               wr_en;
	logic [VAL_W-1:0]   wr_data;
	logic [DIST_W-1:0]  res_dist;
	logic [TOTAL_W-1:0] res_total;
	logic               out_free;
	logic               res_load;

	logic               out_valid_q;
	logic [DIST_W-1:0]  distance_sq_q;
	logic [TOTAL_W-1:0] learning_time_q;
	logic [CMD_W-1:0]   pass_kind_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_rate_q <= LEARNING_RATE_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LEARNING_RATE)) begin
			learning_rate_q <= pwdata[FACT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (psel && (paddr[2] == REG_LEARNING_RATE)) begin
			prdata = PDATA_W'(learning_rate_q);
		end
	end

	sndu_ctrl #(
		.PASS_LEN(PASS_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.last     (last),
		.out_free (out_free),
		.ctrl     (ctrl),
		.addr     (addr)
	);

	sndu_weight_mem u_mem (
		.clk     (clk),
		.rd_en   (ctrl.accept),
		.rd_addr (addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (wr_data)
	);

	sndu_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.value         (value),
		.attenuation   (attenuation),
		.learning_rate (learning_rate_q),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_data       (wr_data),
		.res_dist      (res_dist),
		.res_total     (res_total)
	);

	// The result register frees itself in the same cycle it is taken.
	assign out_free = !out_valid_q || out_ready;
	assign res_load = ctrl.st_done && ctrl.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			distance_sq_q   <= res_dist;
			learning_time_q <= res_total;
			pass_kind_q     <= ctrl.cmd;
		end
	end

	assign out_valid     = out_valid_q;
	assign distance_sq   = distance_sq_q;
	assign learning_time = learning_time_q;
	assign pass_kind     = pass_kind_q;

endmodule
